[rtl/assert_macros.svh]
// assertion helper macros used by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_AT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// overlapping implication outside reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_AT(name, clk, rst, prop, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/lsp_pkg.sv]
// types, codes and saturating arithmetic of the lsp synthesis filter
package lsp_pkg;

   // command codes of the request word
   localparam logic CMD_COEF   = 1'b0;
   localparam logic CMD_FILTER = 1'b1;

   // register index (word address bit) and reset value
   localparam logic       REG_FILTER_ORDER = 1'b0;
   localparam logic [5:0] ORDER_RESET      = 6'd10;

   // tap product rounding: (x * c + 2^12) >>> 13
   localparam logic signed [47:0] TAP_ROUND = 48'sd4096;
   localparam int                 TAP_SHIFT = 13;

   localparam logic signed [47:0] WIDE_MAX = 48'sd2147483647;
   localparam logic signed [47:0] WIDE_MIN = -48'sd2147483648;

   // one delay memory row: an even and an odd tap of both lines
   typedef struct packed {
      logic signed [31:0] s2o;
      logic signed [31:0] s1o;
      logic signed [31:0] s2e;
      logic signed [31:0] s1e;
   } dl_row_type;

   // one coefficient memory row: an even and an odd coefficient
   typedef struct packed {
      logic signed [15:0] c_odd;
      logic signed [15:0] c_even;
   } coef_pair_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > WIDE_MAX) begin
         return WIDE_MAX[31:0];
      end else if (v < WIDE_MIN) begin
         return WIDE_MIN[31:0];
      end
      return v[31:0];
   endfunction

   // 2 * x * c with c in q1.14, rounded half up, saturated
   function automatic logic signed [31:0] tap_product(input logic signed [31:0] x,
                                                      input logic signed [15:0] c);
      logic signed [47:0] p;
      p = 48'(x) * 48'(c);
      return sat32((p + TAP_ROUND) >>> TAP_SHIFT);
   endfunction

   // a + b + c or a + b - c, saturated once
   function automatic logic signed [31:0] sum3_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c,
                                                   input logic               sub);
      logic signed [47:0] cw;
      cw = sub ? -48'(c) : 48'(c);
      return sat32(48'(a) + 48'(b) + cw);
   endfunction

endpackage

[rtl/lsp_synthesis_filter.sv]
// lsp synthesis filter: coefficient table and delay lines held in memories
// a coefficient word is written while the block stays idle; a sample word runs one read-modify-write
// pass over the delay memory, a MUL and an UPD step per row of two taps over ceil(m/2) rows
// (m = order in use), then ACC1, plus ACC2 for an even order, then DONE; the next word is taken
// only back in idle, after the result is registered; a waiting result holds the last step
// reset: delay lines and feedback read as zero, order 10, coefficients undefined until written
`include "assert_macros.svh"

module lsp_synthesis_filter
   import lsp_pkg::*;
#(
   parameter int MAX_ORDER = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [4:0]         req_coef_index,
   input  logic signed [15:0] req_coef_value,
   input  logic signed [31:0] req_sample,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_filtered,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int NPAIR = (MAX_ORDER + 1) / 2;
   localparam int PAW   = (NPAIR > 1) ? $clog2(NPAIR) : 1;
   localparam int MW    = $clog2(MAX_ORDER + 1);
   localparam int IW    = PAW + 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_ACC1,
      ST_ACC2,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [PAW-1:0]     pair_ff, pair_in;
   logic [PAW-1:0]     last_ff, last_in;
   logic               odd_ff, odd_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] x1_ff, x1_in;
   logic signed [31:0] x2_ff, x2_in;
   logic signed [31:0] tp1_ff, tp1_in;
   logic signed [31:0] tp2_ff, tp2_in;
   logic signed [31:0] accp_ff, accp_in;
   logic signed [31:0] accq_ff, accq_in;
   logic               accsub_ff, accsub_in;
   logic signed [31:0] fb_ff, fb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_filtered_ff, rsp_filtered_in;
   logic [5:0]         order_ff, order_in;
   logic [NPAIR-1:0]   row_valid_ff, row_valid_in;

   // memories and their read registers
   dl_row_type         dl_mem [NPAIR];
   coef_pair_type      coef_mem [NPAIR];
   dl_row_type         dl_rd_ff;
   logic               rd_valid_ff;
   coef_pair_type      coef_rd_ff;

   logic               mem_re;
   logic [PAW-1:0]     mem_raddr;
   logic               dl_we;
   dl_row_type         dl_wdata;
   logic               coef_we;
   logic [IW-1:0]      idx_wide;
   logic [PAW-1:0]     coef_waddr;
   logic               req_fire;
   logic               csr_write;

   logic [MW-1:0]      m_eff;
   logic [MW-1:0]      m_minus;
   dl_row_type         dl_cur;
   logic signed [31:0] s1e_new, s2e_new, s1o_new, s2o_new;
   logic               pair_full;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_FILTER_ORDER) ? {26'b0, order_ff} : 32'b0;

   always_comb begin
      order_in = order_ff;
      if (csr_write && (csr_paddr[2] == REG_FILTER_ORDER)) begin
         order_in = csr_pwdata[5:0];
      end
   end

   // coefficient write address and range check
   assign idx_wide   = {{PAW{1'b0}}, req_coef_index};
   assign coef_waddr = idx_wide[PAW:1];
   assign coef_we    = req_fire && (req_command == CMD_COEF) &&
                       (idx_wide < IW'(MAX_ORDER));

   // order clamped to 1..MAX_ORDER
   always_comb begin
      if (order_ff == 6'd0) begin
         m_eff = MW'(1);
      end else if ({1'b0, order_ff} > 7'(MAX_ORDER)) begin
         m_eff = MW'(MAX_ORDER);
      end else begin
         m_eff = MW'(order_ff);
      end
   end
   assign m_minus = m_eff - MW'(1);

   // tap updates of the row just read; rows never written read as zero
   assign dl_cur    = rd_valid_ff ? dl_rd_ff : '0;
   assign s1e_new   = sat32(48'(dl_cur.s1e) - 48'(tp1_ff));
   assign s2e_new   = sat32(48'(dl_cur.s2e) - 48'(tp2_ff));
   assign s1o_new   = sat32(48'(dl_cur.s1o) + 48'(x1_ff));
   assign s2o_new   = sat32(48'(dl_cur.s2o) + 48'(x2_ff));
   assign pair_full = !((pair_ff == last_ff) && odd_ff);

   // shifted row: even tap takes the previous odd tap, odd tap the even one
   always_comb begin
      dl_wdata.s1e = x1_ff;
      dl_wdata.s2e = x2_ff;
      dl_wdata.s1o = pair_full ? s1e_new : dl_cur.s1o;
      dl_wdata.s2o = pair_full ? s2e_new : dl_cur.s2o;
   end

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      pair_in         = pair_ff;
      last_in         = last_ff;
      odd_in          = odd_ff;
      x_in            = x_ff;
      x1_in           = x1_ff;
      x2_in           = x2_ff;
      tp1_in          = tp1_ff;
      tp2_in          = tp2_ff;
      accp_in         = accp_ff;
      accq_in         = accq_ff;
      accsub_in       = accsub_ff;
      fb_in           = fb_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_filtered_in = rsp_filtered_ff;
      row_valid_in    = row_valid_ff;
      mem_re          = 1'b0;
      mem_raddr       = pair_ff + PAW'(1);
      dl_we           = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_FILTER)) begin
               x_in      = req_sample;
               x1_in     = fb_ff;
               x2_in     = fb_ff;
               accp_in   = '0;
               accq_in   = '0;
               accsub_in = 1'b0;
               pair_in   = '0;
               last_in   = PAW'(m_minus >> 1);
               odd_in    = m_eff[0];
               mem_re    = 1'b1;
               mem_raddr = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // tap products, and the previous row's sum into the output
            tp1_in   = tap_product(x1_ff, coef_rd_ff.c_even);
            tp2_in   = tap_product(x2_ff, coef_rd_ff.c_odd);
            x_in     = sum3_sat(x_ff, accp_ff, accq_ff, accsub_ff);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            dl_we                 = 1'b1;
            row_valid_in[pair_ff] = 1'b1;
            accp_in               = s1e_new;
            accq_in               = pair_full ? s2e_new : dl_cur.s2e;
            accsub_in             = !pair_full;
            x1_in                 = s1o_new;
            x2_in                 = s2o_new;
            if (pair_ff == last_ff) begin
               state_in = ST_ACC1;
            end else begin
               pair_in  = pair_ff + PAW'(1);
               mem_re   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_ACC1: begin
            x_in     = sum3_sat(x_ff, accp_ff, accq_ff, accsub_ff);
            state_in = odd_ff ? ST_DONE : ST_ACC2;
         end
         ST_ACC2: begin
            // even order: last odd taps close the output
            x_in     = sum3_sat(x_ff, x1_ff, x2_ff, 1'b1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = x_ff;
               fb_in           = sat32((48'sd1 - 48'(x_ff)) >>> 1);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fb_ff        <= '0;
         order_ff     <= ORDER_RESET;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fb_ff        <= fb_in;
         order_ff     <= order_in;
         row_valid_ff <= row_valid_in;
      end
      pair_ff         <= pair_in;
      last_ff         <= last_in;
      odd_ff          <= odd_in;
      x_ff            <= x_in;
      x1_ff           <= x1_in;
      x2_ff           <= x2_in;
      tp1_ff          <= tp1_in;
      tp2_ff          <= tp2_in;
      accp_ff         <= accp_in;
      accq_ff         <= accq_in;
      accsub_ff       <= accsub_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   // delay line memory, one row of two taps per entry
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[pair_ff] <= dl_wdata;
      end
      if (mem_re) begin
         dl_rd_ff    <= dl_mem[mem_raddr];
         rd_valid_ff <= row_valid_ff[mem_raddr];
      end
   end

   // coefficient memory, even and odd halves written separately
   always_ff @(posedge clock) begin
      if (coef_we && !idx_wide[0]) begin
         coef_mem[coef_waddr].c_even <= req_coef_value;
      end
      if (coef_we && idx_wide[0]) begin
         coef_mem[coef_waddr].c_odd <= req_coef_value;
      end
      if (mem_re) begin
         coef_rd_ff <= coef_mem[mem_raddr];
      end
   end

   // checks
   `ASSERT_IMPLY(a_pair_in_range, clock, reset, (state_ff == ST_MUL) || (state_ff == ST_UPD), pair_ff <= last_ff, "row index past last row of the order")
   `ASSERT_NEXT(a_sample_starts, clock, reset, req_fire && (req_command == CMD_FILTER), (state_ff == ST_MUL) && (pair_ff == '0), "sample word did not start at row zero")
   `ASSERT_NEXT(a_row_marked, clock, reset, state_ff == ST_UPD, row_valid_ff[$past(pair_ff)], "written row not marked valid")
   `ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result raised outside done state")

endmodule
